FILE: src/ttyld_pkg.sv
// Shared types and constants for the terminal line-discipline character engine.
// No dependencies; every module file imports this package.
package ttyld_pkg;

    localparam int unsigned QUEUE_DEPTH = 1024;
    localparam int unsigned COUNT_CAP   = 2047;
    localparam int unsigned LINE_LIMIT  = (QUEUE_DEPTH > COUNT_CAP) ? COUNT_CAP : QUEUE_DEPTH;
    localparam int unsigned LINE_W      = 11;
    localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_LIMIT);

    localparam int unsigned PLAN_DEPTH = 4;
    localparam int unsigned PLAN_AW    = $clog2(PLAN_DEPTH);

    localparam logic [7:0] CH_NL        = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_CARET     = 8'd94;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    localparam int unsigned ADDR_W = 5;

    typedef enum logic [1:0] {
        FUNC_COOK     = 2'd0,
        FUNC_XMIT     = 2'd1,
        FUNC_LINE_END = 2'd2,
        FUNC_NOP      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_COOKED = 2'd1,
        KIND_SIGNAL = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SIG_INTR = 2'd0,
        SIG_QUIT = 2'd1,
        SIG_SUSP = 2'd2
    } sig_t;

    typedef enum logic [2:0] {
        REG_IMODE = 3'd0,
        REG_LMODE = 3'd1,
        REG_OMODE = 3'd2,
        REG_INTR  = 3'd3,
        REG_QUIT  = 3'd4,
        REG_SUSP  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [4:0] imode;
        logic [3:0] lmode;
        logic [4:0] omode;
        logic [7:0] intr_ch;
        logic [7:0] quit_ch;
        logic [7:0] susp_ch;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [1:0] sig;
    } result_t;

    // One accepted item as the back end replays it: up to three results
    typedef struct packed {
        result_t [2:0]     res;
        logic [1:0]        cnt;
        logic [LINE_W-1:0] lines;
    } plan_t;

endpackage

FILE: src/ttyld_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// No dependencies.
interface ttyld_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [1:0] write_space;
    logic       cooked_full;

    modport source (output valid, func, data_byte, write_space, cooked_full, input ready);
    modport sink   (input valid, func, data_byte, write_space, cooked_full, output ready);
endinterface

interface ttyld_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [1:0]  signal_code;
    logic [10:0] lines_ready;
    logic        last;

    modport source (output valid, kind, out_byte, signal_code, lines_ready, last, input ready);
    modport sink   (input valid, kind, out_byte, signal_code, lines_ready, last, output ready);
endinterface

FILE: src/tty_line_discipline_char.sv
// Top level of the terminal line-discipline character engine: APB registers,
// front end, plan queue and back end. Depends on ttyld_pkg, ttyld_if and submodules.
// Throughput: one result per cycle while out_ch.ready is high, from the single output register;
// an item yields one to three results. Inputs are taken each cycle while the 4-entry queue has room.
// Reset: registers return to defaults, line count and queue empty; no clearing pass.
module tty_line_discipline_char (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ttyld_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    ttyld_in_if.sink                     in_ch,
    ttyld_out_if.source                  out_ch
);
    import ttyld_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     cfg_clear;

    plan_t   plan;
    plan_t   head;
    logic    q_not_full;
    logic    q_not_empty;
    logic    take;
    logic    pop;
    result_t out_res;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_clear = 1'b0;
        prdata    = '0;
        case (reg_idx)
            REG_IMODE:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.imode);
            end
            REG_LMODE:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.lmode);
            end
            REG_OMODE:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.omode);
            end
            REG_INTR:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.intr_ch);
            end
            REG_QUIT:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.quit_ch);
            end
            REG_SUSP:
            begin
                cfg_clear = wr_en;
                prdata    = 32'(cfg_reg.susp_ch);
            end
            default:
            begin
                cfg_clear = 1'b0;
                prdata    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.imode   <= 5'd8;
            cfg_reg.lmode   <= 4'd15;
            cfg_reg.omode   <= 5'd3;
            cfg_reg.intr_ch <= 8'd3;
            cfg_reg.quit_ch <= 8'd28;
            cfg_reg.susp_ch <= 8'd26;
        end
        else if (wr_en) begin
            case (reg_idx)
                REG_IMODE: cfg_reg.imode   <= pwdata[4:0];
                REG_LMODE: cfg_reg.lmode   <= pwdata[3:0];
                REG_OMODE: cfg_reg.omode   <= pwdata[4:0];
                REG_INTR:  cfg_reg.intr_ch <= pwdata[7:0];
                REG_QUIT:  cfg_reg.quit_ch <= pwdata[7:0];
                REG_SUSP:  cfg_reg.susp_ch <= pwdata[7:0];
                default:   cfg_reg.imode   <= cfg_reg.imode;
            endcase
        end
    end

    assign in_ch.ready = q_not_full;
    assign take        = in_ch.valid && q_not_full;

    ttyld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cfg_clear   (cfg_clear),
        .take        (take),
        .func        (in_ch.func),
        .data_byte   (in_ch.data_byte),
        .write_space (in_ch.write_space),
        .cooked_full (in_ch.cooked_full),
        .plan        (plan)
    );

    ttyld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (plan),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    ttyld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_res    (out_res),
        .out_lines  (out_ch.lines_ready),
        .out_last   (out_ch.last)
    );

    assign out_ch.kind        = out_res.kind;
    assign out_ch.out_byte    = out_res.data;
    assign out_ch.signal_code = out_res.sig;

endmodule

FILE: src/ttyld_front.sv
// Front end: cooks or post-processes one item into a list of results and keeps
// the canonical line count. Depends on ttyld_pkg.
module ttyld_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttyld_pkg::cfg_t               cfg,
    input  logic                          cfg_clear,
    input  logic                          take,
    input  logic [1:0]                    func,
    input  logic [7:0]                    data_byte,
    input  logic [1:0]                    write_space,
    input  logic                          cooked_full,
    output ttyld_pkg::plan_t              plan
);
    import ttyld_pkg::*;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } post_t;

    function automatic post_t post_fn(input logic [1:0] space, input logic [7:0] c,
                                      input logic [4:0] om);
        post_t p;
        p.cnt = 2'd1;
        p.b0  = c;
        p.b1  = CH_NL;
        if (space == 2'd0) begin
            p.cnt = 2'd0;
        end
        else if (om[0]) begin
            if (c == CH_NL) begin
                if (om[1]) begin
                    p.cnt = (space < 2'd2) ? 2'd0 : 2'd2;
                    p.b0  = CH_CR;
                end
            end
            else if (c == CH_CR) begin
                if (om[2]) begin
                    p.cnt = 2'd0;
                end
                else if (om[3]) begin
                    p.b0 = CH_NL;
                end
            end
            else if (om[4] && c >= 8'd97 && c <= 8'd122) begin
                p.b0 = c - 8'd32;
            end
        end
        return p;
    endfunction

    logic [LINE_W-1:0] line_count_reg;
    logic [LINE_W-1:0] line_count_next;

    logic [1:0] space;
    logic [7:0] c;
    logic       drop;
    logic       sig_hit;
    sig_t       sig_code;
    logic       ctl;
    logic       spc;
    post_t      echo;
    logic [1:0] n;
    result_t [2:0] res;

    always_comb
    begin
        space    = (write_space == 2'd3) ? 2'd2 : write_space;
        c        = data_byte;
        drop     = 1'b0;
        sig_hit  = 1'b0;
        sig_code = SIG_INTR;
        echo     = '0;
        res      = '{default: '{kind: KIND_NONE, data: 8'd0, sig: 2'd0}};
        n        = 2'd0;
        line_count_next = line_count_reg;

        if (cfg.imode[0]) begin
            c[7] = 1'b0;
        end
        if (cfg.imode[1] && c >= 8'd65 && c <= 8'd90) begin
            c = c + 8'd32;
        end
        if (c == CH_CR) begin
            if (cfg.imode[2]) begin
                drop = 1'b1;
            end
            else if (cfg.imode[3]) begin
                c = CH_NL;
            end
        end
        else if (c == CH_NL && cfg.imode[4]) begin
            c = CH_CR;
        end

        if (cfg.lmode[0]) begin
            if (c == cfg.intr_ch) begin
                sig_hit = 1'b1;
                sig_code = SIG_INTR;
            end
            else if (c == cfg.quit_ch) begin
                sig_hit = 1'b1;
                sig_code = SIG_QUIT;
            end
            else if (c == cfg.susp_ch) begin
                sig_hit = 1'b1;
                sig_code = SIG_SUSP;
            end
        end

        ctl = (c < 8'd32) || (c == 8'd127);
        spc = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

        case (func_t'(func))
            FUNC_COOK:
            begin
                if (drop) begin
                    n = 2'd0;
                end
                else if (sig_hit) begin
                    res[0] = '{kind: KIND_SIGNAL, data: 8'd0, sig: sig_code};
                    n = 2'd1;
                end
                else begin
                    if (cfg.lmode[2] && space != 2'd0) begin
                        if (ctl && !spc && cfg.lmode[3]) begin
                            // caret pair: second byte only if a second entry is free
                            echo.cnt = (space == 2'd2) ? 2'd2 : 2'd1;
                            echo.b0  = CH_CARET;
                            echo.b1  = c + CARET_OFFSET;
                        end
                        else begin
                            echo = post_fn(space, c, cfg.omode);
                        end
                    end
                    if (echo.cnt != 2'd0) begin
                        res[0] = '{kind: KIND_WRITE, data: echo.b0, sig: 2'd0};
                    end
                    if (echo.cnt == 2'd2) begin
                        res[1] = '{kind: KIND_WRITE, data: echo.b1, sig: 2'd0};
                    end
                    n = echo.cnt;
                    if (!cooked_full) begin
                        res[n] = '{kind: KIND_COOKED, data: c, sig: 2'd0};
                        n = n + 2'd1;
                    end
                    if (cfg.lmode[1] && c == CH_NL && line_count_reg < LINE_MAX) begin
                        line_count_next = line_count_reg + 1'b1;
                    end
                end
            end
            FUNC_XMIT:
            begin
                echo = post_fn(space, data_byte, cfg.omode);
                if (echo.cnt != 2'd0) begin
                    res[0] = '{kind: KIND_WRITE, data: echo.b0, sig: 2'd0};
                end
                if (echo.cnt == 2'd2) begin
                    res[1] = '{kind: KIND_WRITE, data: echo.b1, sig: 2'd0};
                end
                n = echo.cnt;
            end
            FUNC_LINE_END:
            begin
                if (cfg.lmode[1] && line_count_reg != '0) begin
                    line_count_next = line_count_reg - 1'b1;
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        // an item with no output still reports once
        if (n == 2'd0) begin
            n = 2'd1;
        end

        plan.res   = res;
        plan.cnt   = n;
        plan.lines = line_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_count_reg <= '0;
        end
        else if (cfg_clear) begin
            line_count_reg <= '0;
        end
        else if (take) begin
            line_count_reg <= line_count_next;
        end
    end

endmodule

FILE: src/ttyld_queue.sv
// Short plan queue between the front and back ends, held in flip-flops.
// Depends on ttyld_pkg.
module ttyld_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ttyld_pkg::plan_t push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output ttyld_pkg::plan_t head
);
    import ttyld_pkg::*;

    plan_t mem [PLAN_DEPTH];

    logic [PLAN_AW-1:0] wr_ptr_reg;
    logic [PLAN_AW-1:0] rd_ptr_reg;
    logic [PLAN_AW:0]   count_reg;

    assign not_full  = (count_reg != (PLAN_AW+1)'(PLAN_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/ttyld_back.sv
// Back end: walks the results of the head plan one per cycle, while the output is not stalled,
// into an output register. Depends on ttyld_pkg.
module ttyld_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ttyld_pkg::plan_t              head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ttyld_pkg::result_t            out_res,
    output logic [ttyld_pkg::LINE_W-1:0]  out_lines,
    output logic                          out_last
);
    import ttyld_pkg::*;

    logic              valid_reg;
    logic [1:0]        idx_reg;
    result_t           res_reg;
    logic [LINE_W-1:0] lines_reg;
    logic              last_reg;

    logic    load;
    logic    at_end;
    result_t cur;

    always_comb
    begin
        load   = head_valid && (!valid_reg || out_ready);
        at_end = (idx_reg == head.cnt - 2'd1);
        pop    = load && at_end;
        case (idx_reg)
            2'd0:    cur = head.res[0];
            2'd1:    cur = head.res[1];
            2'd2:    cur = head.res[2];
            default: cur = head.res[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // hold payload while the transaction stalls
    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg   <= cur;
            lines_reg <= head.lines;
            last_reg  <= at_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_lines = lines_reg;
    assign out_last  = last_reg;

endmodule
